// File: design/tga_rle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA RLE terrain decoder package
// Map geometry, derived widths, register indexes and the command record that
// passes from the packet parser to the span generator.
// ----------------------------------------------------------------------------
package tga_rle_pkg;

	localparam int MAP_WIDTH  = 256;
	localparam int MAP_HEIGHT = 256;

	localparam int COL_W  = $clog2(MAP_WIDTH);
	localparam int ROOM_W = COL_W + 1;
	localparam int ROW_W  = (MAP_HEIGHT > 1) ? $clog2(MAP_HEIGHT) : 1;
	localparam int PIX_W  = $clog2(MAP_WIDTH * MAP_HEIGHT + 1);
	localparam int CNT_W  = 8;

	localparam logic [PIX_W-1:0] IMAGE_PIXELS = PIX_W'(MAP_WIDTH * MAP_HEIGHT);
	localparam logic [ROW_W-1:0] LAST_ROW     = ROW_W'(MAP_HEIGHT - 1);

	localparam logic [3:0]       COST_MAX     = 4'd15;
	localparam logic [7:0]       RUN_FLAG     = 8'd128;
	localparam logic [6:0]       COUNT_MASK   = 7'd127;

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_RLE_MODE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_TOP_DOWN = CFG_IDX_W'(1);

	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic [3:0]       cost;
		logic             done;
	} pix_cmd_t;

endpackage

// File: design/tga_rle_byte_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte channel
// Carries one byte of the image pixel data per request.
// ----------------------------------------------------------------------------
interface tga_rle_byte_if import tga_rle_pkg::*;;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface

// File: design/tga_rle_span_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Span channel
// Carries one decoded row span of terrain cost per request.
// ----------------------------------------------------------------------------
interface tga_rle_span_if import tga_rle_pkg::*;;
	logic       valid;
	logic       ready;
	logic [7:0] row;
	logic [7:0] column_start;
	logic [7:0] span_length;
	logic [3:0] cost_value;
	logic       last_of_run;
	logic       image_done;

	modport source (output valid, output row, output column_start, output span_length,
		output cost_value, output last_of_run, output image_done, input ready);
	modport sink   (input valid, input row, input column_start, input span_length,
		input cost_value, input last_of_run, input image_done, output ready);
endinterface

// File: design/tga_rle_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries a register index and the data to write there.
// ----------------------------------------------------------------------------
interface tga_rle_cfg_if import tga_rle_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/tga_rle_terrain_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA RLE terrain decoder
// Turns the pixel data of an 8-bit color-mapped TGA image into row spans of
// terrain cost.
//
// The bytes channel takes one pixel data byte per request. The spans channel
// delivers row spans: row, first column, length, cost, a flag on the last
// span of an input byte and a flag on the span that completes the image.
// The cfg channel writes the run-length mode and row order registers; it is
// always ready. The user must write it only while the decoder is idle; the
// decoder does not enforce this. A pixel byte's first span passes through
// the command queue and the output register. Bytes are taken at one per cycle
// while the queue is not full; a run that crosses a row end gives two spans,
// which the four-entry queue absorbs. Header and discarded bytes give no span.
// Reset selects run-length packets and top-down rows, starts at row zero and
// column zero and awaits a packet header. When the receiver stalls, the
// output register holds its span, the queue fills and the bytes channel
// drops ready once the queue is full.
// ----------------------------------------------------------------------------
module tga_rle_terrain_decoder import tga_rle_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	tga_rle_byte_if.sink   bytes,
	tga_rle_span_if.source spans,
	tga_rle_cfg_if.sink    cfg
);

	logic     rle_mode_q;
	logic     top_down_q;
	logic     q_full;
	logic     push;
	pix_cmd_t push_cmd;
	logic     pop;
	logic     head_valid;
	pix_cmd_t head;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rle_mode_q <= 1'b1;
			top_down_q <= 1'b1;
		end else if (cfg.valid && cfg.ready) begin
			if (cfg.index == REG_RLE_MODE) begin
				rle_mode_q <= cfg.data[0];
			end else if (cfg.index == REG_TOP_DOWN) begin
				top_down_q <= cfg.data[0];
			end
		end
	end

	tga_rle_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.rle_mode (rle_mode_q),
		.bytes    (bytes),
		.q_full   (q_full),
		.push     (push),
		.cmd      (push_cmd)
	);

	tga_rle_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head)
	);

	tga_rle_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.top_down   (top_down_q),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.spans      (spans)
	);

endmodule

// File: design/tga_rle_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet parser
// Classifies each byte as packet header, run value, raw pixel or discarded
// byte, tracks the image pixel count and issues pixel commands.
// ----------------------------------------------------------------------------
module tga_rle_front import tga_rle_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           rle_mode,
	tga_rle_byte_if.sink   bytes,
	input  logic           q_full,
	output logic           push,
	output pix_cmd_t       cmd
);

	localparam logic [1:0] PH_HEADER  = 2'd0;
	localparam logic [1:0] PH_RUNVAL  = 2'd1;
	localparam logic [1:0] PH_RAW     = 2'd2;
	localparam logic [1:0] PH_DISCARD = 2'd3;

	logic [1:0]       phase_q;
	logic [CNT_W-1:0] pkt_left_q;
	logic [PIX_W-1:0] img_left_q;

	logic             accept;
	logic             is_pix;
	logic [CNT_W-1:0] cnt_raw;
	logic             done;
	logic [CNT_W-1:0] pkt_dec;
	logic [PIX_W-1:0] img_next;

	assign bytes.ready = !q_full;
	assign accept      = bytes.valid && bytes.ready;

	assign is_pix  = !rle_mode || (phase_q == PH_RUNVAL) || (phase_q == PH_RAW);
	assign cnt_raw = (rle_mode && (phase_q == PH_RUNVAL)) ? pkt_left_q : CNT_W'(1);
	assign done    = PIX_W'(cnt_raw) >= img_left_q;
	assign img_next = done ? IMAGE_PIXELS : (img_left_q - PIX_W'(cnt_raw));
	assign pkt_dec = (pkt_left_q != '0) ? (pkt_left_q - CNT_W'(1)) : pkt_left_q;

	assign push       = accept && is_pix;
	assign cmd.count  = done ? CNT_W'(img_left_q) : cnt_raw;
	assign cmd.cost   = COST_MAX - bytes.data_byte[7:4];
	assign cmd.done   = done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			pkt_left_q <= '0;
			img_left_q <= IMAGE_PIXELS;
		end else if (accept) begin
			if (is_pix) begin
				img_left_q <= img_next;
			end
			if (!rle_mode) begin
				if (done) begin
					phase_q    <= PH_HEADER;
					pkt_left_q <= '0;
				end
			end else begin
				unique case (phase_q)
					PH_HEADER: begin
						pkt_left_q <= CNT_W'(bytes.data_byte[6:0] & COUNT_MASK) + CNT_W'(1);
						phase_q    <= ((bytes.data_byte & RUN_FLAG) != '0) ? PH_RUNVAL : PH_RAW;
					end
					PH_RUNVAL: begin
						pkt_left_q <= '0;
						phase_q    <= PH_HEADER;
					end
					PH_RAW: begin
						pkt_left_q <= pkt_dec;
						if (pkt_dec == '0) begin
							phase_q <= PH_HEADER;
						end else if (done) begin
							phase_q <= PH_DISCARD;
						end
					end
					PH_DISCARD: begin
						pkt_left_q <= pkt_dec;
						if (pkt_dec == '0) begin
							phase_q <= PH_HEADER;
						end
					end
					default: begin
						phase_q <= PH_HEADER;
					end
				endcase
			end
		end
	end

endmodule

// File: design/tga_rle_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command queue
// Short FIFO of pixel commands between the packet parser and the span
// generator, with simultaneous push and pop.
// ----------------------------------------------------------------------------
module tga_rle_queue import tga_rle_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  pix_cmd_t push_cmd,
	input  logic     pop,
	output logic     full,
	output logic     head_valid,
	output pix_cmd_t head
);

	pix_cmd_t        mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_AW:0]   fill_q;
	logic            do_pop;

	assign full       = fill_q == (Q_AW + 1)'(Q_DEPTH);
	assign head_valid = fill_q != '0;
	assign head       = mem_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + Q_AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + Q_AW'(1);
			end
			if (push && !do_pop) begin
				fill_q <= fill_q + (Q_AW + 1)'(1);
			end else if (!push && do_pop) begin
				fill_q <= fill_q - (Q_AW + 1)'(1);
			end
		end
	end

endmodule

// File: design/tga_rle_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Span generator
// Places pixel commands on the map, splits them at row ends, steps the row
// in the chosen direction and rearms at the end of the image.
// ----------------------------------------------------------------------------
module tga_rle_back import tga_rle_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           top_down,
	input  logic           head_valid,
	input  pix_cmd_t       head,
	output logic           pop,
	tga_rle_span_if.source spans
);

	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic              split_q;
	logic [CNT_W-1:0]  rem_q;

	logic              out_valid_q;
	logic [ROW_W-1:0]  out_row_q;
	logic [COL_W-1:0]  out_col_q;
	logic [CNT_W-1:0]  out_len_q;
	logic [3:0]        out_cost_q;
	logic              out_last_q;
	logic              out_done_q;

	logic              advance;
	logic [CNT_W-1:0]  cur_cnt;
	logic [ROOM_W-1:0] room;
	logic              fits;
	logic [CNT_W-1:0]  len;
	logic [ROOM_W-1:0] col_end;
	logic              wrap;
	logic [ROW_W-1:0]  row_step;
	logic [ROW_W-1:0]  first_row;

	assign advance   = head_valid && (!out_valid_q || spans.ready);
	assign cur_cnt   = split_q ? rem_q : head.count;
	assign room      = ROOM_W'(MAP_WIDTH) - ROOM_W'(col_q);
	assign fits      = ROOM_W'(cur_cnt) <= room;
	assign len       = fits ? cur_cnt : CNT_W'(room);
	assign col_end   = ROOM_W'(col_q) + ROOM_W'(len);
	assign wrap      = col_end == ROOM_W'(MAP_WIDTH);
	assign first_row = top_down ? '0 : LAST_ROW;
	assign pop       = advance && fits;

	always_comb begin
		if (top_down) begin
			row_step = (row_q == LAST_ROW) ? '0 : row_q + ROW_W'(1);
		end else begin
			row_step = (row_q == '0) ? LAST_ROW : row_q - ROW_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			split_q     <= 1'b0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				split_q     <= !fits;
				rem_q       <= cur_cnt - len;
				if (fits && head.done) begin
					col_q <= '0;
					row_q <= first_row;
				end else if (wrap) begin
					col_q <= '0;
					row_q <= row_step;
				end else begin
					col_q <= COL_W'(col_end);
				end
			end else if (spans.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_row_q  <= row_q;
			out_col_q  <= col_q;
			out_len_q  <= len;
			out_cost_q <= head.cost;
			out_last_q <= fits;
			out_done_q <= fits && head.done;
		end
	end

	assign spans.valid        = out_valid_q;
	assign spans.row          = 8'(out_row_q);
	assign spans.column_start = 8'(out_col_q);
	assign spans.span_length  = out_len_q;
	assign spans.cost_value   = out_cost_q;
	assign spans.last_of_run  = out_last_q;
	assign spans.image_done   = out_done_q;

endmodule

// File: design/tga_rle_props.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA RLE decoder port properties
// Watches the span channel of the decoder for rule breaks over time.
// ----------------------------------------------------------------------------
module tga_rle_props import tga_rle_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] span_length,
	input logic [7:0] column_start,
	input logic       last_of_run,
	input logic       image_done
);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(span_length)
			&& $stable(column_start) && $stable(image_done))
		else $error("Span request changed while stalled.");

	a_length_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (span_length != 8'd0) && (span_length <= 8'd128))
		else $error("Span length out of range.");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && image_done |-> last_of_run)
		else $error("Image end span is not the last span of its byte.");

	a_not_last_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_run |=> out_valid && column_start == 8'd0)
		else $error("Split span does not continue at the start of a row.");

endmodule

bind tga_rle_terrain_decoder tga_rle_props u_props (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (spans.valid),
	.out_ready    (spans.ready),
	.span_length  (spans.span_length),
	.column_start (spans.column_start),
	.last_of_run  (spans.last_of_run),
	.image_done   (spans.image_done)
);

// File: test/tb_tga_rle_terrain_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA RLE terrain decoder testbench
// Sends pixel data bytes through the byte channel and compares every span
// with an in-bench decoder. A short directed list covers packet headers,
// mode and row order changes and row wrap, followed by random packet streams
// that run into image ends, runs and raw packets cut at the image end,
// and random stalls on both channels, including one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_tga_rle_terrain_decoder;
	import tga_rle_pkg::*;

	typedef struct packed {
		logic [7:0] row;
		logic [7:0] column_start;
		logic [7:0] span_length;
		logic [3:0] cost_value;
		logic       last_of_run;
		logic       image_done;
	} span_t;

	typedef enum logic [1:0] {AWAIT_HEADER, AWAIT_RUN_VALUE, RAW_PIXELS, DROP_RAW} pkt_phase_t;
	typedef enum logic {STEP_BYTE, STEP_WRITE} step_kind_t;

	typedef struct {
		step_kind_t kind;
		logic [7:0] idx;
		logic [7:0] value;
		bit         typed;
		span_t      want;
	} step_t;

	logic clk;
	logic arst_n;

	tga_rle_byte_if byte_ch ();
	tga_rle_span_if span_ch ();
	tga_rle_cfg_if  cfg_ch ();

	tga_rle_terrain_decoder uut (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (byte_ch),
		.spans  (span_ch),
		.cfg    (cfg_ch)
	);

	bit                mode_rle;
	bit                rows_down;
	pkt_phase_t        phase;
	int unsigned       pkt_left;
	int unsigned       col;
	logic [ROW_W-1:0]  row;
	int unsigned       pix_left;

	span_t  pending_spans[$];
	span_t  fresh[$];
	step_t  plan[$];
	span_t  head;

	int     errors;
	int     spans_seen;
	int     bytes_sent;
	int     images_done;
	int     raw_cuts;
	bit     tx_burst;
	bit     squeeze_req;
	bit     squeeze_done;
	bit     squeezing;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic void restart_image();
		col = 0;
		row = rows_down ? '0 : LAST_ROW;
		pix_left = MAP_WIDTH * MAP_HEIGHT;
	endfunction

	function automatic bit paint(int unsigned count, logic [3:0] cost);
		span_t       pair[2];
		int unsigned len;
		int          n;
		bit          fin;
		n = 0;
		fin = 1'b0;
		while (count > 0 && n < 2 && !fin) begin
			len = MAP_WIDTH - col;
			if (len > count) len = count;
			if (len > pix_left) len = pix_left;
			if (len == 0) len = 1;
			pair[n] = '{8'(row), 8'(col), 8'(len), cost, 1'b0, 1'b0};
			count -= len;
			col += len;
			if (col >= MAP_WIDTH) begin
				col = 0;
				if (rows_down) row = (row == LAST_ROW) ? '0 : row + 1'b1;
				else row = (row == '0) ? LAST_ROW : row - 1'b1;
			end
			pix_left = (pix_left > len) ? pix_left - len : 0;
			if (pix_left == 0) begin
				pair[n].image_done = 1'b1;
				fin = 1'b1;
				images_done++;
				restart_image();
			end
			n++;
		end
		if (n > 0) pair[n-1].last_of_run = 1'b1;
		for (int i = 0; i < n; i++) fresh.push_back(pair[i]);
		return fin;
	endfunction

	function automatic void decode_byte(logic [7:0] b);
		logic [3:0] cost;
		bit         fin;
		cost = COST_MAX - b[7:4];
		if (!mode_rle) begin
			if (paint(1, cost)) begin
				phase = AWAIT_HEADER;
				pkt_left = 0;
			end
			return;
		end
		case (phase)
			AWAIT_HEADER: begin
				pkt_left = int'(b[6:0] & COUNT_MASK) + 1;
				phase = ((b & RUN_FLAG) != 0) ? AWAIT_RUN_VALUE : RAW_PIXELS;
			end
			AWAIT_RUN_VALUE: begin
				void'(paint(pkt_left, cost));
				pkt_left = 0;
				phase = AWAIT_HEADER;
			end
			RAW_PIXELS: begin
				fin = paint(1, cost);
				if (pkt_left > 0) pkt_left--;
				if (pkt_left == 0) phase = AWAIT_HEADER;
				else if (fin) begin
					phase = DROP_RAW;
					raw_cuts++;
				end
			end
			default: begin
				if (pkt_left > 0) pkt_left--;
				if (pkt_left == 0) phase = AWAIT_HEADER;
			end
		endcase
	endfunction

	function automatic logic [7:0] pick_byte();
		if (!mode_rle || phase != AWAIT_HEADER || $urandom_range(0, 49) == 0)
			return 8'($urandom_range(0, 255));
		if (pix_left <= 128)
			return {1'($urandom_range(0, 1)), 7'($urandom_range(127, pix_left - 1))};
		if ($urandom_range(0, 99) < 95)
			return {1'b1, ($urandom_range(0, 9) < 9) ? COUNT_MASK : 7'($urandom_range(0, 127))};
		return {1'b0, ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127)) :
			7'($urandom_range(0, 7))};
	endfunction

	function automatic span_t want_span(int r, int c, int len, int cost);
		return '{8'(r), 8'(c), 8'(len), 4'(cost), 1'b1, 1'b0};
	endfunction

	function automatic void add_step(step_kind_t kind, logic [7:0] idx, logic [7:0] value,
		bit typed, span_t want);
		step_t s;
		s.kind = kind;
		s.idx = idx;
		s.value = value;
		s.typed = typed;
		s.want = want;
		plan.push_back(s);
	endfunction

	function automatic void check_field(string what, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t ns: span %s expected %0d, got %0d", $time, what, want, got);
		end
	endfunction

	task automatic send_byte(logic [7:0] b, bit typed, span_t want);
		int gap;
		gap = (tx_burst || squeezing) ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_ch.data_byte <= b;
		byte_ch.valid <= 1'b1;
		do @(posedge clk); while (!byte_ch.ready);
		bytes_sent++;
		if (bytes_sent % 64 == 0) tx_burst = ($urandom_range(0, 3) == 0);
		decode_byte(b);
		if (typed) begin
			fresh.delete();
			pending_spans.push_back(want);
		end else begin
			while (fresh.size() > 0) pending_spans.push_back(fresh.pop_front());
		end
	endtask

	task automatic write_reg(logic [7:0] idx, logic [7:0] value);
		byte_ch.valid <= 1'b0;
		while (pending_spans.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		cfg_ch.valid <= 1'b1;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		if (idx == REG_RLE_MODE) mode_rle = value[0];
		else if (idx == REG_TOP_DOWN) rows_down = value[0];
	endtask

	always @(posedge clk) begin
		if (arst_n && span_ch.valid && span_ch.ready) begin
			spans_seen++;
			if (pending_spans.size() == 0) begin
				errors++;
				$display("%0t ns: span expected none, got row %0d col %0d len %0d cost %0d",
					$time, span_ch.row, span_ch.column_start, span_ch.span_length,
					span_ch.cost_value);
			end else begin
				head = pending_spans.pop_front();
				check_field("row", head.row, span_ch.row);
				check_field("column_start", head.column_start, span_ch.column_start);
				check_field("span_length", head.span_length, span_ch.span_length);
				check_field("cost_value", 8'(head.cost_value), 8'(span_ch.cost_value));
				check_field("last_of_run", 8'(head.last_of_run), 8'(span_ch.last_of_run));
				check_field("image_done", 8'(head.image_done), 8'(span_ch.image_done));
			end
		end
	end

	initial begin
		int  n;
		int  taken;
		bit  rx_burst;
		span_ch.ready <= 1'b0;
		taken = 0;
		rx_burst = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			n = rx_burst ? 0 : $urandom_range(0, 11);
			if (squeeze_req && !squeeze_done) begin
				squeeze_done = 1'b1;
				squeezing = 1'b1;
				n = 80;
			end
			if (n > 0) begin
				span_ch.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			squeezing = 1'b0;
			span_ch.ready <= 1'b1;
			do @(posedge clk); while (!span_ch.valid);
			taken++;
			if (taken % 50 == 0) rx_burst = ($urandom_range(0, 3) == 0);
		end
	end

	initial begin
		int n;
		byte_ch.valid <= 1'b0;
		byte_ch.data_byte <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= '0;
		cfg_ch.data <= '0;
		arst_n = 1'b0;
		mode_rle = 1'b1;
		rows_down = 1'b1;
		phase = AWAIT_HEADER;
		pkt_left = 0;
		restart_image();

		add_step(STEP_BYTE, 8'd0, 8'hFF, 1'b0, '0);
		add_step(STEP_BYTE, 8'd0, 8'h00, 1'b1, want_span(0, 0, 128, 15));
		add_step(STEP_BYTE, 8'd0, 8'hFF, 1'b0, '0);
		add_step(STEP_BYTE, 8'd0, 8'hF0, 1'b1, want_span(0, 128, 128, 0));
		add_step(STEP_BYTE, 8'd0, 8'h02, 1'b0, '0);
		add_step(STEP_BYTE, 8'd0, 8'h12, 1'b1, want_span(1, 0, 1, 14));
		add_step(STEP_BYTE, 8'd0, 8'h80, 1'b1, want_span(1, 1, 1, 7));
		add_step(STEP_WRITE, REG_RLE_MODE, 8'd0, 1'b0, '0);
		add_step(STEP_BYTE, 8'd0, 8'h7F, 1'b1, want_span(1, 2, 1, 8));
		add_step(STEP_WRITE, REG_RLE_MODE, 8'd1, 1'b0, '0);
		add_step(STEP_BYTE, 8'd0, 8'h3C, 1'b1, want_span(1, 3, 1, 12));
		add_step(STEP_BYTE, 8'd0, 8'h80, 1'b0, '0);
		add_step(STEP_BYTE, 8'd0, 8'h55, 1'b1, want_span(1, 4, 1, 10));
		add_step(STEP_BYTE, 8'd0, 8'h00, 1'b0, '0);
		add_step(STEP_BYTE, 8'd0, 8'hA0, 1'b1, want_span(1, 5, 1, 5));
		add_step(STEP_WRITE, REG_TOP_DOWN, 8'd0, 1'b0, '0);
		add_step(STEP_BYTE, 8'd0, 8'hFF, 1'b0, '0);
		add_step(STEP_BYTE, 8'd0, 8'h0F, 1'b0, '0);
		add_step(STEP_BYTE, 8'd0, 8'hFF, 1'b0, '0);
		add_step(STEP_BYTE, 8'd0, 8'h9E, 1'b0, '0);
		add_step(STEP_BYTE, 8'd0, 8'hFF, 1'b0, '0);
		add_step(STEP_BYTE, 8'd0, 8'hFF, 1'b0, '0);
		add_step(STEP_BYTE, 8'd0, 8'hFF, 1'b0, '0);
		add_step(STEP_BYTE, 8'd0, 8'h61, 1'b0, '0);
		add_step(STEP_WRITE, REG_TOP_DOWN, 8'd1, 1'b0, '0);
		add_step(STEP_WRITE, REG_RLE_MODE, 8'd0, 1'b0, '0);
		add_step(STEP_BYTE, 8'd0, 8'h00, 1'b0, '0);
		add_step(STEP_BYTE, 8'd0, 8'hFF, 1'b0, '0);
		add_step(STEP_WRITE, REG_RLE_MODE, 8'd1, 1'b0, '0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == STEP_WRITE) write_reg(plan[i].idx, plan[i].value);
			else send_byte(plan[i].value, plan[i].typed, plan[i].want);
		end

		while (bytes_sent < 2000) begin
			write_reg(REG_RLE_MODE, 8'($urandom_range(0, 4) != 0));
			write_reg(REG_TOP_DOWN, 8'($urandom_range(0, 1)));
			n = mode_rle ? $urandom_range(150, 400) : $urandom_range(20, 80);
			repeat (n) begin
				if (bytes_sent == 400) squeeze_req = 1'b1;
				send_byte(pick_byte(), 1'b0, '0);
			end
		end

		byte_ch.valid <= 1'b0;
		while (pending_spans.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("Sent %0d bytes in both modes and row orders, checked %0d spans.",
			bytes_sent, spans_seen);
		$display("Completed %0d images, cut %0d raw packets at the image end.",
			images_done, raw_cuts);
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
